/* rtl/dar_pkg.sv */
// Shared types and status codes for the DNS A-record response parser.
`timescale 1ns / 1ps
`default_nettype none

package dar_pkg;

  // One payload byte of the datagram.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dar_in_t;

  // One result word: hostname character or end-of-packet verdict.
  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [2:0]  status;
    logic [15:0] query_id;
    logic [1:0]  addr_count;
    logic [31:0] addr_first;
    logic [31:0] addr_second;
    logic [31:0] addr_third;
  } dar_out_t;

  // Result kinds.
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRUNCATED  = 3'd1;
  localparam logic [2:0] ST_NOT_RESP   = 3'd2;
  localparam logic [2:0] ST_BAD_COUNTS = 3'd3;
  localparam logic [2:0] ST_BAD_QUERY  = 3'd4;
  localparam logic [2:0] ST_BAD_V4_LEN = 3'd5;
  localparam logic [2:0] ST_NAME_LONG  = 3'd6;

  // Protocol constants.
  localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
  localparam logic [15:0] TYPE_A        = 16'd1;
  localparam logic [15:0] CLASS_IN      = 16'd1;
  localparam logic [15:0] V4_LEN        = 16'd4;
  localparam logic [3:0]  HDR_LAST_IDX  = 4'd11;
  localparam logic [3:0]  RR_LAST_IDX   = 4'd11;

endpackage

`default_nettype wire

/* rtl/dns_a_response_parser.sv */
// Top level: byte-serial DNS response parser with A-record extraction.
`timescale 1ns / 1ps
`default_nettype none

// Takes one datagram byte per cycle on the input channel and parses it in a
// single registered pass: every accepted byte updates the parse state and,
// when it produces a result, writes one word into the output register or its
// skid entry. Sustained rate is one byte per clock; the only thing that holds
// the input off is back-pressure on the output once both the output register
// and the one-entry skid register behind it are full. Results are hostname
// characters (kind 0, dots between labels) streamed while the query name goes
// by, and one verdict word (kind 1) on the byte marked last, carrying status,
// transaction id and up to three IPv4 addresses from type A / class IN answers.
// Answer names are assumed to be 2-byte pointers. After the verdict the
// control state clears for the next datagram. MAX_ADDRS caps the addresses
// kept (parsing stops once reached); MAX_NAME caps the hostname length.
module dns_a_response_parser #(
  parameter int MAX_ADDRS = 3,
  parameter int MAX_NAME  = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dar_pkg::dar_in_t in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dar_pkg::dar_out_t     out_word_o
);

  localparam int CntW  = $clog2(MAX_ADDRS + 1);
  localparam int NameW = $clog2(MAX_NAME + 1);

  // Parse phases.
  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_NAME  = 3'd1;
  localparam logic [2:0] PH_QTAIL = 3'd2;
  localparam logic [2:0] PH_RRHDR = 3'd3;
  localparam logic [2:0] PH_ADDR  = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  logic [2:0]       phase_q, phase_d;
  logic [3:0]       fidx_q, fidx_d;
  logic [31:0]      shift_q, shift_d;
  logic [15:0]      txid_q, txid_d;
  logic [15:0]      ans_left_q, ans_left_d;
  logic [7:0]       label_left_q, label_left_d;
  logic [NameW-1:0] name_len_q, name_len_d;
  logic             rr_is_type_a_q, rr_is_type_a_d;   // answer type == A
  logic             rr_is_class_in_q, rr_is_class_in_d; // answer class == IN
  logic [15:0]      rr_left_q, rr_left_d;
  logic [CntW-1:0]  found_cnt_q, found_cnt_d;
  logic [31:0]      found_q [MAX_ADDRS];
  logic [31:0]      found_d [MAX_ADDRS];
  logic [2:0]       verdict_q, verdict_d;

  logic [31:0]      slot_w [3];

  logic              accept_in;
  logic              res_fire;
  dar_pkg::dar_out_t res_w;

  // Output register and skid entry.
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  dar_pkg::dar_out_t out_q, out_d;
  dar_pkg::dar_out_t skid_q, skid_d;
  logic              out_take;

  assign in_stall_o = skid_valid_q;
  assign accept_in  = in_valid_i && !skid_valid_q;

  // Address slots of the verdict, padded to three.
  for (genvar k = 0; k < 3; k++) begin : g_slot
    if (k < MAX_ADDRS) begin : g_have
      assign slot_w[k] = found_d[k];
    end else begin : g_none
      assign slot_w[k] = '0;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        emit;
    logic [7:0]  ch;
    logic        finish;
    logic        room;
    logic        is_a;
    logic [15:0] ans_dec;
    logic [2:0]  verdict_fin;
    logic [CntW+1:0] cnt_ext;

    b      = in_word_i.data_byte;
    last   = in_word_i.last_byte;
    emit   = 1'b0;
    ch     = '0;
    finish = 1'b0;
    room   = 1'b0;
    is_a   = 1'b0;
    ans_dec = '0;
    verdict_fin = '0;
    cnt_ext = '0;

    phase_d          = phase_q;
    fidx_d           = fidx_q;
    shift_d          = shift_q;
    txid_d           = txid_q;
    ans_left_d       = ans_left_q;
    label_left_d     = label_left_q;
    name_len_d       = name_len_q;
    rr_is_type_a_d   = rr_is_type_a_q;
    rr_is_class_in_d = rr_is_class_in_q;
    rr_left_d        = rr_left_q;
    found_cnt_d      = found_cnt_q;
    found_d          = found_q;
    verdict_d        = verdict_q;
    res_w            = '0;
    res_fire         = 1'b0;

    if (accept_in) begin
      // Room for one more hostname character.
      room = (32'(name_len_q) < MAX_NAME);

      unique case (phase_q)
        PH_HDR: begin
          shift_d = {shift_q[23:0], b};
          if (fidx_q == 4'd1) txid_d = shift_d[15:0];
          if (fidx_q == 4'd3 && (shift_d[15:0] & dar_pkg::FLAG_RESPONSE) == 16'd0 &&
              verdict_q == dar_pkg::ST_OK) begin
            verdict_d = dar_pkg::ST_NOT_RESP;
          end
          if (fidx_q == 4'd5 && shift_d[15:0] != 16'd1 &&
              verdict_d == dar_pkg::ST_OK) begin
            verdict_d = dar_pkg::ST_BAD_COUNTS;
          end
          if (fidx_q == 4'd7) begin
            ans_left_d = shift_d[15:0];
            if (shift_d[15:0] == 16'd0 && verdict_d == dar_pkg::ST_OK) begin
              verdict_d = dar_pkg::ST_BAD_COUNTS;
            end
          end
          if (fidx_q >= dar_pkg::HDR_LAST_IDX) begin
            fidx_d  = '0;
            phase_d = (verdict_d != dar_pkg::ST_OK) ? PH_DONE : PH_NAME;
          end else begin
            fidx_d = fidx_q + 4'd1;
          end
        end
        PH_NAME: begin
          if (label_left_q == 8'd0) begin
            if (b == 8'd0) begin
              phase_d = PH_QTAIL;
              fidx_d  = '0;
            end else begin
              label_left_d = b;
              if (name_len_q != '0) begin
                if (room) begin
                  name_len_d = name_len_q + NameW'(1);
                  emit       = 1'b1;
                  ch         = 8'h2e;  // '.'
                end else begin
                  verdict_d = dar_pkg::ST_NAME_LONG;
                  phase_d   = PH_DONE;
                end
              end
            end
          end else begin
            label_left_d = label_left_q - 8'd1;
            if (room) begin
              name_len_d = name_len_q + NameW'(1);
              emit       = 1'b1;
              ch         = b;
            end else begin
              verdict_d = dar_pkg::ST_NAME_LONG;
              phase_d   = PH_DONE;
            end
          end
        end
        PH_QTAIL: begin
          shift_d = {shift_q[23:0], b};
          if (fidx_q >= 4'd3) begin
            fidx_d = '0;
            if (shift_d[31:16] != dar_pkg::TYPE_A || shift_d[15:0] != dar_pkg::CLASS_IN) begin
              verdict_d = dar_pkg::ST_BAD_QUERY;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_RRHDR;
            end
          end else begin
            fidx_d = fidx_q + 4'd1;
          end
        end
        PH_RRHDR: begin
          shift_d = {shift_q[23:0], b};
          if (fidx_q == 4'd3) rr_is_type_a_d   = (shift_d[15:0] == dar_pkg::TYPE_A);
          if (fidx_q == 4'd5) rr_is_class_in_d = (shift_d[15:0] == dar_pkg::CLASS_IN);
          if (fidx_q >= dar_pkg::RR_LAST_IDX) begin
            is_a      = rr_is_type_a_d && rr_is_class_in_d;
            rr_left_d = shift_d[15:0];
            fidx_d    = '0;
            if (is_a && shift_d[15:0] == dar_pkg::V4_LEN) begin
              phase_d = PH_ADDR;
            end else begin
              if (is_a) verdict_d = dar_pkg::ST_BAD_V4_LEN;
              if (shift_d[15:0] == 16'd0) begin
                finish = 1'b1;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end else begin
            fidx_d = fidx_q + 4'd1;
          end
        end
        PH_ADDR: begin
          shift_d = {shift_q[23:0], b};
          if (fidx_q >= 4'd3) begin
            if (32'(found_cnt_q) < MAX_ADDRS) begin
              for (int i = 0; i < MAX_ADDRS; i++) begin
                if (32'(found_cnt_q) == i) found_d[i] = shift_d;
              end
              found_cnt_d = found_cnt_q + CntW'(1);
            end
            finish = 1'b1;
          end else begin
            fidx_d = fidx_q + 4'd1;
          end
        end
        PH_SKIP: begin
          rr_left_d = rr_left_q - 16'd1;
          if (rr_left_d == 16'd0) finish = 1'b1;
        end
        default: begin
        end
      endcase

      // End of one answer record.
      if (finish) begin
        fidx_d = '0;
        if (verdict_d != dar_pkg::ST_OK) begin
          phase_d = PH_DONE;
        end else begin
          ans_dec    = ans_left_q - 16'd1;
          ans_left_d = ans_dec;
          if (ans_dec == 16'd0 || 32'(found_cnt_d) >= MAX_ADDRS) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_RRHDR;
          end
        end
      end

      if (last) begin
        verdict_fin = (phase_d != PH_DONE) ? dar_pkg::ST_TRUNCATED : verdict_d;
        cnt_ext     = {2'b00, found_cnt_d};
        res_fire          = 1'b1;
        res_w.kind        = dar_pkg::KIND_VERDICT;
        res_w.status      = verdict_fin;
        res_w.query_id    = txid_d;
        if (verdict_fin == dar_pkg::ST_OK) begin
          res_w.addr_count  = cnt_ext[1:0];
          res_w.addr_first  = (32'(found_cnt_d) > 0) ? slot_w[0] : '0;
          res_w.addr_second = (32'(found_cnt_d) > 1) ? slot_w[1] : '0;
          res_w.addr_third  = (32'(found_cnt_d) > 2) ? slot_w[2] : '0;
        end
        // Clear for the next datagram.
        phase_d          = PH_HDR;
        fidx_d           = '0;
        txid_d           = '0;
        ans_left_d       = '0;
        label_left_d     = '0;
        name_len_d       = '0;
        rr_is_type_a_d   = 1'b0;
        rr_is_class_in_d = 1'b0;
        rr_left_d        = '0;
        found_cnt_d      = '0;
        verdict_d        = dar_pkg::ST_OK;
      end else if (emit) begin
        res_fire        = 1'b1;
        res_w.kind      = dar_pkg::KIND_CHAR;
        res_w.name_char = ch;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        // No new word can arrive while the skid entry is full.
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_w;
        out_valid_d = res_fire;
      end
    end else if (res_fire) begin
      skid_d       = res_w;
      skid_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HDR;
      fidx_q           <= '0;
      txid_q           <= '0;
      ans_left_q       <= '0;
      label_left_q     <= '0;
      name_len_q       <= '0;
      rr_is_type_a_q   <= 1'b0;
      rr_is_class_in_q <= 1'b0;
      rr_left_q        <= '0;
      found_cnt_q      <= '0;
      verdict_q        <= dar_pkg::ST_OK;
      out_valid_q      <= 1'b0;
      skid_valid_q     <= 1'b0;
    end else begin
      phase_q          <= phase_d;
      fidx_q           <= fidx_d;
      txid_q           <= txid_d;
      ans_left_q       <= ans_left_d;
      label_left_q     <= label_left_d;
      name_len_q       <= name_len_d;
      rr_is_type_a_q   <= rr_is_type_a_d;
      rr_is_class_in_q <= rr_is_class_in_d;
      rr_left_q        <= rr_left_d;
      found_cnt_q      <= found_cnt_d;
      verdict_q        <= verdict_d;
      out_valid_q      <= out_valid_d;
      skid_valid_q     <= skid_valid_d;
    end
  end

  // Payload registers: field shifter, kept addresses, output words.
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    found_q <= found_d;
    out_q   <= out_d;
    skid_q  <= skid_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_char_word_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == dar_pkg::KIND_CHAR |->
      out_word_o.status == dar_pkg::ST_OK && out_word_o.query_id == 16'd0 &&
      out_word_o.addr_count == 2'd0)
    else $error("character word carries verdict fields");

  a_fail_no_addrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == dar_pkg::KIND_VERDICT &&
      out_word_o.status != dar_pkg::ST_OK |->
      out_word_o.addr_count == 2'd0 && out_word_o.addr_first == 32'd0)
    else $error("failed verdict reports addresses");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without output back-pressure");

endmodule

`default_nettype wire
